// ===== hw/rtl/hrld_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP response line deframer package
// Shared codes, character constants, result bundle and small helper functions.
// ----------------------------------------------------------------------------
package hrld_pkg;

	// Default size of the line store in characters.
	localparam int LINE_MAX_DEF = 256;

	// Beat kinds on the input stream.
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_NEW     = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	// Event codes on the output stream.
	localparam logic [2:0] EV_CHAR       = 3'd0;
	localparam logic [2:0] EV_HDR_LINE   = 3'd1;
	localparam logic [2:0] EV_HDR_END    = 3'd2;
	localparam logic [2:0] EV_PAY_LINE   = 3'd3;
	localparam logic [2:0] EV_CHUNK_LINE = 3'd4;
	localparam logic [2:0] EV_CHUNK_DONE = 3'd5;
	localparam logic [2:0] EV_CHUNK_ERR  = 3'd6;

	// Characters the parser looks for.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_C = 8'h63;

	// Index of the last character of the transfer coding keyword.
	localparam logic [2:0] PAT_LAST = 3'd6;

	// Chunk head depth and the index that means "receiving data".
	localparam logic [2:0] HEAD_DATA = 3'd4;

	// Width of the chunk byte counter: up to three hex digits plus sign.
	localparam int BLW = 13;

	// One result beat as produced by the parser core.
	typedef struct packed {
		logic       vld;
		logic [2:0] ev;
		logic [7:0] byte_val;
		logic [7:0] len;
		logic       chunked;
	} res_t;

	// Keyword "chunked", one character per position.
	function automatic logic [7:0] pat_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h63;
			3'd1: ch = 8'h68;
			3'd2: ch = 8'h75;
			3'd3: ch = 8'h6E;
			3'd4: ch = 8'h6B;
			3'd5: ch = 8'h65;
			3'd6: ch = 8'h64;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Hex digit decode: bit 4 flags a valid digit, bits 3:0 its value.
	function automatic logic [4:0] hex_dec(input logic [7:0] ch);
		logic [4:0] r;
		r = 5'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			r = {1'b1, 4'(ch - 8'h30)};
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			r = {1'b1, 4'(ch - 8'h57)};
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			r = {1'b1, 4'(ch - 8'h37)};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/hrld_core.sv =====
// ----------------------------------------------------------------------------
// HTTP response line deframer parser core
// Holds the parser state and turns one beat into at most one result.
// ----------------------------------------------------------------------------
module hrld_core import hrld_pkg::*; #(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [1:0] kind,
	input  logic [7:0] data_byte,
	input  logic       verdict_flush,
	output res_t       res
);

	localparam int LCW = $clog2(LINE_MAX);
	localparam logic [LCW-1:0] LINE_FULL = LCW'(LINE_MAX - 1);

	logic                  in_header_q, n_in_header;
	logic                  chunked_q, n_chunked;
	logic                  flush_q, n_flush;
	logic [LCW-1:0]        line_q, n_line;
	logic [2:0]            mprog_q, n_mprog;
	logic                  mfound_q, n_mfound;
	logic [2:0]            hidx_q, n_hidx;
	logic [3:0][7:0]       head_q, n_head;
	logic signed [BLW-1:0] bleft_q, n_bleft;

	logic [LCW+7:0]        line_ext;
	logic [LCW+7:0]        nline_ext;

	assign line_ext  = {8'd0, line_q};
	assign nline_ext = {8'd0, n_line};

	// Next-state and result logic for one beat.
	always_comb begin
		logic [7:0]  c;
		logic [7:0]  hb;
		logic [4:0]  hd;
		logic        stop;
		logic [11:0] size;
		logic        done;
		c           = data_byte;
		hb          = 8'd0;
		hd          = 5'd0;
		stop        = 1'b0;
		size        = 12'd0;
		done        = 1'b0;
		n_in_header = in_header_q;
		n_chunked   = chunked_q;
		n_flush     = flush_q;
		n_line      = line_q;
		n_mprog     = mprog_q;
		n_mfound    = mfound_q;
		n_hidx      = hidx_q;
		n_head      = head_q;
		n_bleft     = bleft_q;
		res         = '0;
		if (fire) begin
			case (kind)
				KIND_NEW: begin
					n_in_header = 1'b1;
					n_chunked   = 1'b0;
					n_flush     = 1'b0;
					n_line      = '0;
					n_mprog     = 3'd0;
					n_mfound    = 1'b0;
					n_hidx      = 3'd0;
					n_head      = '0;
					n_bleft     = '0;
				end
				KIND_VERDICT: begin
					n_flush = verdict_flush;
				end
				KIND_BYTE: begin
					if (c != CH_CR) begin
						if (in_header_q) begin
							// Header phase: collect lines and watch for the keyword.
							if (c == CH_LF) begin
								if (line_q == '0) begin
									n_in_header = 1'b0;
									n_flush     = 1'b0;
									res.vld     = 1'b1;
									res.ev      = EV_HDR_END;
								end else begin
									if (!flush_q && mfound_q) begin
										n_chunked = 1'b1;
										n_flush   = 1'b1;
									end
									if (!flush_q) begin
										res.vld = 1'b1;
										res.ev  = EV_HDR_LINE;
										res.len = line_ext[7:0];
									end
								end
								n_line   = '0;
								n_mprog  = 3'd0;
								n_mfound = 1'b0;
							end else if (!flush_q && line_q < LINE_FULL) begin
								n_line = line_q + LCW'(1);
								if (c == pat_char(mprog_q)) begin
									if (mprog_q == PAT_LAST) begin
										n_mfound = 1'b1;
										n_mprog  = 3'd0;
									end else begin
										n_mprog = mprog_q + 3'd1;
									end
								end else begin
									n_mprog = (c == CH_LOW_C) ? 3'd1 : 3'd0;
								end
								res.vld      = 1'b1;
								res.ev       = EV_CHAR;
								res.byte_val = c;
								res.len      = nline_ext[7:0];
							end
						end else if (chunked_q) begin
							if (hidx_q < HEAD_DATA) begin
								// Chunk head: gather bytes until a newline.
								if (!(hidx_q == 3'd0 && c < CH_ZERO)) begin
									n_head[hidx_q[1:0]] = c;
									n_hidx = hidx_q + 3'd1;
									if (c == CH_LF) begin
										for (int i = 0; i < 4; i++) begin
											hb = (3'(i) == hidx_q) ? c : head_q[i];
											hd = hex_dec(hb);
											if (!stop && hd[4]) begin
												size = {size[7:0], hd[3:0]};
											end else begin
												stop = 1'b1;
											end
										end
										n_bleft = $signed({1'b0, size});
										n_hidx  = HEAD_DATA;
									end
								end
							end else if (bleft_q > 0) begin
								// Chunk data: count down and store printable bytes.
								n_bleft = bleft_q - BLW'(1);
								if (c == CH_LF) begin
									if (!flush_q) begin
										res.vld = 1'b1;
										res.ev  = EV_CHUNK_LINE;
										res.len = line_ext[7:0];
									end
								end else if (c >= CH_SPACE && line_q < LINE_FULL) begin
									n_line       = line_q + LCW'(1);
									res.vld      = 1'b1;
									res.ev       = EV_CHAR;
									res.byte_val = c;
									res.len      = nline_ext[7:0];
								end
							end else begin
								// After the data a newline must follow.
								n_bleft = '1;
								if (c != CH_LF) begin
									res.vld      = 1'b1;
									res.ev       = EV_CHUNK_ERR;
									res.byte_val = c;
									res.len      = line_ext[7:0];
								end else begin
									done   = (head_q[0] == CH_ZERO) && (head_q[1] == CH_LF);
									n_hidx = 3'd0;
									n_head = '0;
									if (done) begin
										n_line  = '0;
										res.vld = 1'b1;
										res.ev  = EV_CHUNK_DONE;
										res.len = line_ext[7:0];
									end
								end
							end
						end else begin
							// Plain body: frame into lines.
							if (c == CH_LF) begin
								n_line   = '0;
								n_mprog  = 3'd0;
								n_mfound = 1'b0;
								if (!flush_q) begin
									res.vld = 1'b1;
									res.ev  = EV_PAY_LINE;
									res.len = line_ext[7:0];
								end
							end else if (!flush_q && line_q < LINE_FULL) begin
								n_line       = line_q + LCW'(1);
								res.vld      = 1'b1;
								res.ev       = EV_CHAR;
								res.byte_val = c;
								res.len      = nline_ext[7:0];
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		res.chunked = n_chunked;
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q <= 1'b1;
			chunked_q   <= 1'b0;
			flush_q     <= 1'b0;
			line_q      <= '0;
			mprog_q     <= 3'd0;
			mfound_q    <= 1'b0;
			hidx_q      <= 3'd0;
			head_q      <= '0;
			bleft_q     <= '0;
		end else begin
			in_header_q <= n_in_header;
			chunked_q   <= n_chunked;
			flush_q     <= n_flush;
			line_q      <= n_line;
			mprog_q     <= n_mprog;
			mfound_q    <= n_mfound;
			hidx_q      <= n_hidx;
			head_q      <= n_head;
			bleft_q     <= n_bleft;
		end
	end

	// The head index never passes the data position.
	a_hidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		hidx_q <= HEAD_DATA)
		else $error("chunk head index out of range");

	// The chunk byte counter saturates at minus one.
	a_bleft_floor: assert property (@(posedge clk) disable iff (!arst_n)
		bleft_q >= -1)
		else $error("chunk byte counter below minus one");

	// A new response returns the parser to the header phase with an empty line.
	a_new_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind == KIND_NEW) |=> (in_header_q && line_q == '0 && !chunked_q))
		else $error("new response did not reset parser");

	// Results only appear for an accepted stream byte.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		res.vld |-> (fire && kind == KIND_BYTE && data_byte != CH_CR))
		else $error("result without a stream byte");

	// The keyword match only progresses in the header phase.
	a_match_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(mprog_q != $past(mprog_q) && mprog_q != 3'd0) |-> $past(in_header_q))
		else $error("keyword match outside header");

endmodule

// ===== hw/rtl/http_response_line_deframer.sv =====
// ----------------------------------------------------------------------------
// HTTP response line deframer
// Drops CR, frames header and body lines, decodes chunked transfer coding.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_*       in         tuser[1:0] kind; tdata[7:0] data_byte, [8] verdict_flush
//  m_*       out        tuser[2:0] event_res; tdata[7:0] out_byte,
//                       [15:8] line_length, [16] is_chunked
//
// One beat is accepted per cycle while s_tready is high. A beat is held in the
// input register and parsed by the core; any result lands in the output
// register, from which it is offered on m_*. The input register frees whenever
// the output register is empty or being taken, so back pressure on m_* stalls
// the input by one beat of slack only. Reset (arst_n low) returns the parser
// to the header phase and empties both registers; there is no clearing pass.
// ----------------------------------------------------------------------------
module http_response_line_deframer import hrld_pkg::*; #(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] verdict_flush, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [15:8] line_length, [16] is_chunked
	output logic [2:0]  m_tuser    // [2:0] event_res
);

	logic       vld_s1;
	logic [1:0] kind_s1;
	logic [7:0] byte_s1;
	logic       verd_s1;
	logic       advance;
	res_t       res;
	logic       m_vld_q;
	logic [2:0] ev_q;
	logic [7:0] byte_q;
	logic [7:0] len_q;
	logic       chunked_q;

	// The held beat moves on when the output register can take its result.
	assign advance  = vld_s1 && (!m_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata[7:0];
			verd_s1 <= s_tdata[8];
		end
	end

	hrld_core #(
		.LINE_MAX (LINE_MAX)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.kind          (kind_s1),
		.data_byte     (byte_s1),
		.verdict_flush (verd_s1),
		.res           (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (advance) begin
			m_vld_q <= res.vld;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.vld) begin
			ev_q      <= res.ev;
			byte_q    <= res.byte_val;
			len_q     <= res.len;
			chunked_q <= res.chunked;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tuser  = ev_q;
	assign m_tdata  = {7'd0, chunked_q, len_q, byte_q};

	// A pending result is held until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_vld_q && !m_tready) |=> (m_vld_q && $stable(ev_q) && $stable(byte_q)))
		else $error("pending result changed under stall");

	// The input register only stalls while a result waits downstream.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && m_vld_q && !m_tready))
		else $error("input stalled without back pressure");

	// Event codes stay within the defined set.
	a_ev_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_vld_q |-> (ev_q <= EV_CHUNK_ERR))
		else $error("undefined event code");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the HTTP response line deframer
// Drives whole responses (header lines, blank line, plain or chunked body)
// plus verdicts, noise and broken chunk framing into the input stream. A
// scoreboard predicts every event beat and compares it with the output stream
// while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import hrld_pkg::*; ();

	// Kind code that the block must ignore.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Transfer coding keyword, first character in the top byte.
	localparam logic [55:0] KEYWORD = "chunked";

	localparam int PHASE_BEATS  = 25;
	localparam int LONG_HOLD    = 64;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	// One predicted or observed event beat.
	typedef struct packed {
		logic [2:0] ev;
		logic [7:0] ob;
		logic [7:0] len;
		logic       chk;
	} deframe_evt_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'h0000;   // [7:0] data_byte, [8] verdict_flush, rest zero
	logic [1:0]  s_tuser = 2'b00;      // [1:0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;              // [7:0] out_byte, [15:8] line_length, [16] is_chunked
	logic [2:0]  m_tuser;              // [2:0] event_res

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int beats_sent = 0;
	int responses = 0;
	int cycle_count = 0;

	// ------------------------------------------------------------------------
	// Scoreboard: a behavioural copy of the parser and the queue of events
	// that it has predicted but the block has not yet delivered.
	// ------------------------------------------------------------------------
	class deframe_scoreboard;
		deframe_evt_t pending_events[$];
		int           mismatches;
		int           checked;
		int           ev_seen[7];

		bit           in_hdr;
		bit           chunk_mode;
		bit           flush;
		int           line_cnt;
		int           kw_pos;
		bit           kw_hit;
		int           head_pos;
		logic [7:0]   head[4];
		int           remaining;

		function new();
			mismatches = 0;
			checked = 0;
			foreach (ev_seen[i]) ev_seen[i] = 0;
			restart();
		endfunction

		// State after reset or at the start of a new response.
		function void restart();
			in_hdr = 1'b1;
			chunk_mode = 1'b0;
			flush = 1'b0;
			drop_line();
			head_pos = 0;
			foreach (head[i]) head[i] = 8'h00;
			remaining = 0;
		endfunction

		function void drop_line();
			line_cnt = 0;
			kw_pos = 0;
			kw_hit = 1'b0;
		endfunction

		function bit emit(input logic [2:0] ev, input logic [7:0] b, input int len,
				output deframe_evt_t e);
			e.ev = ev;
			e.ob = b;
			e.len = 8'(len);
			e.chk = chunk_mode;
			return 1'b1;
		endfunction

		// Advances the copy by one accepted beat; returns 1 when it yields an event.
		function bit parse_beat(input logic [1:0] kind, input logic [7:0] c, input logic f,
				output deframe_evt_t e);
			int len;
			int size;
			int v;
			int i;
			bit was_flush;
			bit done;
			e = '0;
			if (kind == KIND_NEW) begin
				restart();
				return 1'b0;
			end
			if (kind == KIND_VERDICT) begin
				flush = f;
				return 1'b0;
			end
			if (kind != KIND_BYTE || c == CH_CR) return 1'b0;

			// Header phase: collect lines and look for the keyword.
			if (in_hdr) begin
				if (c == CH_LF) begin
					len = line_cnt;
					if (len == 0) begin
						in_hdr = 1'b0;
						flush = 1'b0;
						drop_line();
						return emit(EV_HDR_END, 8'h00, 0, e);
					end
					was_flush = flush;
					if (!was_flush && kw_hit) begin
						chunk_mode = 1'b1;
						flush = 1'b1;
					end
					drop_line();
					if (was_flush) return 1'b0;
					return emit(EV_HDR_LINE, 8'h00, len, e);
				end
				if (!flush && line_cnt < LINE_MAX_DEF - 1) begin
					line_cnt++;
					if (c == KEYWORD[8*(6-kw_pos) +: 8]) begin
						kw_pos++;
						if (kw_pos >= 7) begin
							kw_hit = 1'b1;
							kw_pos = 0;
						end
					end else begin
						kw_pos = (c == CH_LOW_C) ? 1 : 0;
					end
					return emit(EV_CHAR, c, line_cnt, e);
				end
				return 1'b0;
			end

			// Plain body: frame lines.
			if (!chunk_mode) begin
				if (c == CH_LF) begin
					len = line_cnt;
					drop_line();
					if (flush) return 1'b0;
					return emit(EV_PAY_LINE, 8'h00, len, e);
				end
				if (!flush && line_cnt < LINE_MAX_DEF - 1) begin
					line_cnt++;
					return emit(EV_CHAR, c, line_cnt, e);
				end
				return 1'b0;
			end

			// Chunked body: collect the head and read the size on its newline.
			if (head_pos < 4) begin
				if (head_pos == 0 && c < CH_ZERO) return 1'b0;
				head[head_pos] = c;
				head_pos++;
				if (c != CH_LF) return 1'b0;
				size = 0;
				i = 0;
				v = 0;
				while (i < 4 && v >= 0) begin
					if (head[i] >= "0" && head[i] <= "9") v = head[i] - "0";
					else if (head[i] >= "a" && head[i] <= "f") v = head[i] - "a" + 10;
					else if (head[i] >= "A" && head[i] <= "F") v = head[i] - "A" + 10;
					else v = -1;
					if (v >= 0) size = size * 16 + v;
					i++;
				end
				remaining = size;
				head_pos = 4;
				return 1'b0;
			end

			// Chunk data bytes.
			if (remaining > 0) begin
				remaining--;
				if (c == CH_LF) begin
					if (flush) return 1'b0;
					return emit(EV_CHUNK_LINE, 8'h00, line_cnt, e);
				end
				if (c >= CH_SPACE && line_cnt < LINE_MAX_DEF - 1) begin
					line_cnt++;
					return emit(EV_CHAR, c, line_cnt, e);
				end
				return 1'b0;
			end

			// After the data only a newline is allowed.
			remaining = -1;
			if (c != CH_LF) return emit(EV_CHUNK_ERR, c, line_cnt, e);
			done = (head[0] == CH_ZERO && head[1] == CH_LF);
			len = line_cnt;
			head_pos = 0;
			foreach (head[j]) head[j] = 8'h00;
			if (done) begin
				line_cnt = 0;
				return emit(EV_CHUNK_DONE, 8'h00, len, e);
			end
			return 1'b0;
		endfunction

		function void note_beat(input logic [1:0] kind, input logic [7:0] c, input logic f);
			deframe_evt_t e;
			if (parse_beat(kind, c, f, e)) pending_events.push_back(e);
		endfunction

		task report_mismatch(input string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_event(input logic [2:0] ev, input logic [7:0] ob, input logic [7:0] len,
				input logic chk);
			deframe_evt_t want;
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event %0d byte %02h len %0d chunked %0b",
					ev, ob, len, chk));
				return;
			end
			want = pending_events.pop_front();
			checked++;
			ev_seen[want.ev]++;
			if (ev !== want.ev || ob !== want.ob || len !== want.len || chk !== want.chk) begin
				report_mismatch({
					$sformatf("got ev %0d byte %02h len %0d chunked %0b, ",
						ev, ob, len, chk),
					$sformatf("want ev %0d byte %02h len %0d chunked %0b",
						want.ev, want.ob, want.len, want.chk)});
			end
		endtask
	endclass

	deframe_scoreboard sb;

	http_response_line_deframer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Clock with a 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold whenever one is asked for.
	always @(posedge clk) begin
		if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Output monitor: every accepted event beat goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_event(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[16]);
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top failed");
		$finish;
	end

	// Offers one beat, with random idle cycles first, and waits for its acceptance.
	task automatic send_beat(input logic [1:0] kind, input logic [7:0] b, input logic f);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {7'b0, f, b};
		do @(posedge clk); while (!s_tready);
		sb.note_beat(kind, b, f);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(KIND_BYTE, s[i], 1'b0);
	endtask

	// Line end: usually CR LF, sometimes a bare LF.
	task automatic send_eol();
		if ($urandom_range(3, 0) != 0) send_beat(KIND_BYTE, CH_CR, 1'b0);
		send_beat(KIND_BYTE, CH_LF, 1'b0);
	endtask

	// Mostly printable text with the odd arbitrary byte.
	task automatic send_rand_text(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(15, 0) == 0)
				send_beat(KIND_BYTE, 8'($urandom_range(255, 0)), 1'b0);
			else
				send_beat(KIND_BYTE, 8'($urandom_range(8'h7E, 8'h20)), 1'b0);
		end
	endtask

	task automatic send_verdict();
		send_beat(KIND_VERDICT, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
	endtask

	// One response: new-response beat, header, blank line, then a body.
	task automatic send_response(input bit long_line);
		bit chunk_body;
		int n;
		int size;
		send_beat(KIND_NEW, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
		responses++;
		chunk_body = ($urandom_range(2, 0) != 0);
		n = $urandom_range(2, 0);
		for (int i = 0; i < n; i++) begin
			send_rand_text($urandom_range(12, 1));
			send_eol();
		end
		if (chunk_body) begin
			case ($urandom_range(3, 0))
				0: send_text("Transfer-Encoding: chunked");
				1: send_text("Transfer-Encoding: Chunked");
				2: send_text("TE: chunkchunked");
				default: send_text("TE: chunke");
			endcase
			send_eol();
		end
		// A line longer than the store holds.
		if (long_line) begin
			send_rand_text(LINE_MAX_DEF + 4);
			send_eol();
		end
		if ($urandom_range(3, 0) == 0) send_verdict();
		send_eol();

		if (chunk_body) begin
			// Usually clear the flush flag so that chunk lines are reported.
			if ($urandom_range(3, 0) != 0)
				send_beat(KIND_VERDICT, 8'($urandom_range(255, 0)), 1'b0);
			n = $urandom_range(3, 0);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(15, 0) == 0) size = $urandom_range(16'h10F, 16'h100);
				else size = $urandom_range(12, 1);
				if ($urandom_range(3, 0) == 0)
					send_beat(KIND_BYTE, 8'($urandom_range(8'h2F, 8'h00)), 1'b0);
				if ($urandom_range(1, 0) != 0) send_text($sformatf("%0x", size));
				else send_text($sformatf("%0X", size));
				if ($urandom_range(9, 0) == 0) send_text(";ext");
				send_eol();
				for (int i = 0; i < size; i++) begin
					case ($urandom_range(15, 0))
						0, 1: send_beat(KIND_BYTE, CH_LF, 1'b0);
						2: send_beat(KIND_BYTE, 8'($urandom_range(255, 0)), 1'b0);
						default: send_beat(KIND_BYTE, 8'($urandom_range(8'h7E, 8'h20)), 1'b0);
					endcase
				end
				// Occasionally stray bytes before the line end.
				if ($urandom_range(5, 0) == 0) send_rand_text($urandom_range(2, 1));
				send_eol();
			end
			if ($urandom_range(7, 0) != 0) begin
				send_text("0");
				send_eol();
				send_eol();
			end
		end else begin
			n = $urandom_range(4, 1);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(5, 0) == 0) send_verdict();
				send_rand_text($urandom_range(20, 0));
				send_eol();
			end
		end

		// Noise of any kind.
		if ($urandom_range(4, 0) == 0) begin
			n = $urandom_range(3, 1);
			for (int i = 0; i < n; i++)
				send_beat(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
					1'($urandom_range(1, 0)));
		end
	endtask

	// Sender stops and waits until every predicted event has been delivered.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: ignored kind, keyword header, chunk with newline in its data,
		// stray byte after a chunk, final zero chunk with a stray byte before its last newline.
		send_beat(KIND_UNUSED, 8'hFF, 1'b1);
		send_beat(KIND_NEW, 8'h00, 1'b0);
		send_text("chunked");
		send_beat(KIND_BYTE, CH_CR, 1'b0);
		send_beat(KIND_BYTE, CH_LF, 1'b0);
		send_beat(KIND_BYTE, CH_LF, 1'b0);
		send_beat(KIND_VERDICT, 8'h00, 1'b0);
		send_beat(KIND_BYTE, 8'h00, 1'b0);
		send_text("2");
		send_beat(KIND_BYTE, CH_LF, 1'b0);
		send_text("a");
		send_beat(KIND_BYTE, CH_LF, 1'b0);
		send_text("x");
		send_beat(KIND_BYTE, CH_LF, 1'b0);
		send_text("0");
		send_beat(KIND_BYTE, CH_LF, 1'b0);
		send_beat(KIND_BYTE, 8'hFF, 1'b0);
		send_beat(KIND_BYTE, CH_LF, 1'b0);
		send_beat(KIND_VERDICT, 8'hFF, 1'b1);
		send_beat(KIND_BYTE, 8'hFF, 1'b0);
		wait_drained();

		// Random responses under four idling regimes.
		for (int phase = 0; phase < 4; phase++) begin
			int quota;
			bit first;
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 71;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 71;
					hold_asked++;
				end
				default: begin
					send_idle_pct = 35;
					recv_stall_pct = 35;
				end
			endcase
			quota = beats_sent + PHASE_BEATS;
			first = 1'b1;
			while (beats_sent < quota) begin
				send_response(phase == 1 && first);
				first = 1'b0;
			end
			wait_drained();
		end

		$display("Run covered %0d input beats in %0d responses, %0d events checked.",
			beats_sent, responses, sb.checked);
		$display(
			"Events: char %0d, hdr line %0d, hdr end %0d, line %0d, chunk %0d, done %0d, err %0d",
			sb.ev_seen[EV_CHAR], sb.ev_seen[EV_HDR_LINE], sb.ev_seen[EV_HDR_END],
			sb.ev_seen[EV_PAY_LINE], sb.ev_seen[EV_CHUNK_LINE], sb.ev_seen[EV_CHUNK_DONE],
			sb.ev_seen[EV_CHUNK_ERR]);
		if (sb.mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
